// ----- rtl/core/fcdma_pkg.sv -----
// Shared types, codes and constants of the four-channel DMA controller.
// Used by the controller, the datapath and the top level; depends on nothing.
package fcdma_pkg;

    localparam int NumChannels    = 4;
    localparam int DefaultAddrBits = 28;
    localparam int OutAddrBits    = 28;

    localparam logic [2:0] ACT_READ   = 3'd0;
    localparam logic [2:0] ACT_WRITE  = 3'd1;
    localparam logic [2:0] ACT_DREQ   = 3'd2;
    localparam logic [2:0] ACT_TICK   = 3'd3;
    localparam logic [2:0] ACT_MODULE = 3'd4;
    localparam logic [2:0] ACT_NMI    = 3'd5;

    localparam logic [2:0] OFF_SAR_HI = 3'd0;
    localparam logic [2:0] OFF_SAR_LO = 3'd1;
    localparam logic [2:0] OFF_DAR_HI = 3'd2;
    localparam logic [2:0] OFF_DAR_LO = 3'd3;
    localparam logic [2:0] OFF_DMAOR  = 3'd4;
    localparam logic [2:0] OFF_TCR    = 3'd5;
    localparam logic [2:0] OFF_CHCR   = 3'd7;

    localparam logic [3:0] RS_DREQ_DUAL = 4'h0;
    localparam logic [3:0] RS_DACK_DST  = 4'h2;
    localparam logic [3:0] RS_DACK_SRC  = 4'h3;
    localparam logic [3:0] RS_AUTO      = 4'hC;
    localparam logic [3:0] RS_MOD_LO    = 4'h4;
    localparam logic [3:0] RS_MOD_HI    = 4'hB;
    localparam logic [3:0] RS_MOD_EXTRA = 4'hD;

    localparam logic [2:0] NO_OWNER = 3'd4;
    localparam logic [15:0] DMAOR_WR_MASK = 16'h0301;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       exec;
        logic       unit;
        logic [1:0] unit_ch;
        logic       push;
        logic       push_last;
        logic       push_served;
        logic       push_blank;
    } t_dp_cmd;

    typedef struct packed {
        logic       is_module;
        logic [3:0] match;
        logic       out_free;
    } t_dp_status;

    typedef struct packed {
        logic [15:0]            read_data;
        logic                   xvalid;
        logic [1:0]             ch;
        logic [OutAddrBits-1:0] src;
        logic [OutAddrBits-1:0] dst;
        logic                   word;
        logic                   src_dack;
        logic                   dst_dack;
        logic                   aerr;
    } t_xfer;

endpackage

// ----- rtl/core/fcdma_ctrl.sv -----
// Controller state machine of the DMA controller: sequences one input item
// through execute, module-request scan and result hand-off. Uses fcdma_pkg.
module fcdma_ctrl import fcdma_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_scan, n_scan;
    logic       r_pend, n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scan  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
            r_pend  <= n_pend;
        end
    end

    // Next state and scan bookkeeping.
    always_comb begin
        n_state = r_state;
        n_scan  = r_scan;
        n_pend  = r_pend;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.is_module) begin
                    n_state = S_SCAN;
                    n_scan  = '0;
                    n_pend  = 1'b0;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                if (r_scan[2]) begin
                    if (i_status.out_free) n_state = S_IDLE;
                end else if (i_status.match[r_scan[1:0]]) begin
                    if (r_pend) begin
                        if (i_status.out_free) n_pend = 1'b0;
                    end else begin
                        n_pend = 1'b1;
                        n_scan = r_scan + 3'd1;
                    end
                end else begin
                    n_scan = r_scan + 3'd1;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = !i_status.is_module;
            end
            S_SCAN: begin
                if (r_scan[2]) begin
                    o_cmd.push        = i_status.out_free;
                    o_cmd.push_last   = 1'b1;
                    o_cmd.push_served = r_pend;
                    o_cmd.push_blank  = !r_pend;
                end else if (i_status.match[r_scan[1:0]]) begin
                    if (r_pend) begin
                        o_cmd.push        = i_status.out_free;
                        o_cmd.push_served = 1'b1;
                    end else begin
                        o_cmd.unit    = 1'b1;
                        o_cmd.unit_ch = r_scan[1:0];
                    end
                end
            end
            S_EMIT: begin
                o_cmd.push      = i_status.out_free;
                o_cmd.push_last = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- rtl/core/fcdma_dp.sv -----
// Datapath of the DMA controller: channel registers, DMAOR, DREQ tracking,
// channel pick, the transfer-unit engine and the output register. Uses fcdma_pkg.
module fcdma_dp import fcdma_pkg::*; #(
    parameter int ADDR_BITS = DefaultAddrBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_action,
    input  logic [25:0] i_item,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic        o_valid,
    input  logic        i_ready,
    output t_xfer       o_xfer,
    output logic [3:0]  o_irq,
    output logic        o_served,
    output logic        o_last
);

    localparam logic [31:0] AMask =
        (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

    logic [31:0] r_sar     [NumChannels];
    logic [31:0] r_dar     [NumChannels];
    logic [15:0] r_tcr     [NumChannels];
    logic [15:0] r_chcr    [NumChannels];
    logic [3:0]  r_te_seen;
    logic [1:0]  r_edge;
    logic [1:0]  r_level;
    logic [15:0] r_dmaor;
    logic [1:0]  r_flags_rd;   // bit 0 NMIF, bit 1 AE seen set by a read
    logic [2:0]  r_owner;

    logic [2:0]  r_act;
    logic [1:0]  r_ch;
    logic [2:0]  r_off;
    logic [15:0] r_wd;
    logic        r_low;
    logic [3:0]  r_req;
    t_xfer       r_res;

    logic        r_ovalid;
    t_xfer       r_out;
    logic [3:0]  r_oirq;
    logic        r_oserved;
    logic        r_olast;

    logic [3:0]  en, rdy, irq_now, mod_match;
    logic [1:0]  pick_ch;
    logic        pick_ok;
    logic        tick_unit, do_unit;
    logic [1:0]  u;
    logic [15:0] c;
    logic [3:0]  rs;
    logic        word, sd, dd, err;
    logic [31:0] step, sar_n, dar_n, amw;
    logic [15:0] tcr_n;
    logic        more;
    logic        out_free;
    logic [15:0] rd_val;

    always_comb begin
        for (int k = 0; k < NumChannels; k++) begin
            en[k] = r_chcr[k][0] && !r_chcr[k][1] && r_dmaor[0] && !r_dmaor[1] && !r_dmaor[2];
            rdy[k] = en[k] && ((r_chcr[k][11:8] == RS_AUTO) ||
                (k < 2 && (r_chcr[k][11:8] == RS_DREQ_DUAL || r_chcr[k][11:8] == RS_DACK_DST ||
                 r_chcr[k][11:8] == RS_DACK_SRC) &&
                 (r_chcr[k][5] ? r_edge[k % 2] : r_level[k % 2])));
            mod_match[k] = en[k] && r_chcr[k][11:8] == r_req &&
                ((r_chcr[k][11:8] >= RS_MOD_LO && r_chcr[k][11:8] <= RS_MOD_HI) ||
                 r_chcr[k][11:8] == RS_MOD_EXTRA);
            irq_now[k] = r_chcr[k][1] && r_chcr[k][2];
        end
    end

    // Tick pick: a live burst owner keeps the channel, else the priority order that DMAOR selects.
    always_comb begin
        pick_ok = 1'b1;
        pick_ch = 2'd0;
        if (!r_owner[2] && en[r_owner[1:0]] && r_chcr[r_owner[1:0]][4]) begin
            pick_ch = r_owner[1:0];
        end else if (r_dmaor[9:8] == 2'd1) begin
            priority if (rdy[1]) pick_ch = 2'd1;
            else if (rdy[3]) pick_ch = 2'd3;
            else if (rdy[2]) pick_ch = 2'd2;
            else if (rdy[0]) pick_ch = 2'd0;
            else pick_ok = 1'b0;
        end else begin
            priority if (rdy[0]) pick_ch = 2'd0;
            else if (rdy[3]) pick_ch = 2'd3;
            else if (rdy[2]) pick_ch = 2'd2;
            else if (rdy[1]) pick_ch = 2'd1;
            else pick_ok = 1'b0;
        end
    end

    assign tick_unit = i_cmd.exec && r_act == ACT_TICK && pick_ok;
    assign do_unit   = i_cmd.unit || tick_unit;
    assign u         = i_cmd.unit ? i_cmd.unit_ch : pick_ch;

    // Transfer-unit engine on channel u.
    always_comb begin
        c     = r_chcr[u];
        word  = c[3];
        rs    = c[11:8];
        sd    = rs == RS_DACK_SRC;
        dd    = rs == RS_DACK_DST;
        err   = word && ((!sd && r_sar[u][0]) || (!dd && r_dar[u][0]));
        step  = word ? 32'd2 : 32'd1;
        amw   = AMask & {31'h7FFF_FFFF, !word};
        sar_n = r_sar[u];
        dar_n = r_dar[u];
        if (!sd && c[13:12] == 2'd1) sar_n = r_sar[u] + step;
        if (!sd && c[13:12] == 2'd2) sar_n = r_sar[u] - step;
        if (!dd && c[15:14] == 2'd1) dar_n = r_dar[u] + step;
        if (!dd && c[15:14] == 2'd2) dar_n = r_dar[u] - step;
        tcr_n = r_tcr[u] - 16'd1;
        more  = !err && tcr_n != 16'd0;
    end

    // Register read value; zero for anything but a read.
    always_comb begin
        rd_val = '0;
        if (r_act == ACT_READ) begin
            unique case (r_off)
                OFF_SAR_HI: rd_val = r_sar[r_ch][31:16];
                OFF_SAR_LO: rd_val = r_sar[r_ch][15:0];
                OFF_DAR_HI: rd_val = r_dar[r_ch][31:16];
                OFF_DAR_LO: rd_val = r_dar[r_ch][15:0];
                OFF_DMAOR:  rd_val = (r_ch == 2'd0) ? r_dmaor : 16'd0;
                OFF_TCR:    rd_val = r_tcr[r_ch];
                OFF_CHCR:   rd_val = r_chcr[r_ch];
                default:    rd_val = '0;
            endcase
        end
    end

    assign out_free = !r_ovalid || i_ready;
    assign o_status = '{is_module: r_act == ACT_MODULE, match: mod_match, out_free: out_free};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumChannels; k++) begin
                r_sar[k]  <= '0;
                r_dar[k]  <= '0;
                r_tcr[k]  <= '0;
                r_chcr[k] <= '0;
            end
            r_te_seen  <= '0;
            r_edge     <= '0;
            r_level    <= '0;
            r_dmaor    <= '0;
            r_flags_rd <= '0;
            r_owner    <= NO_OWNER;
            r_ovalid   <= 1'b0;
        end else begin
            if (do_unit) begin
                r_sar[u] <= sar_n;
                r_dar[u] <= dar_n;
                r_tcr[u] <= tcr_n;
                if (err) r_dmaor[2] <= 1'b1;
                else if (tcr_n == 16'd0) r_chcr[u][1] <= 1'b1;
            end
            if (tick_unit) begin
                if (!u[1]) r_edge[u[0]] <= 1'b0;
                r_owner <= (c[4] && more) ? {1'b0, u} : NO_OWNER;
            end else if (i_cmd.exec && r_act == ACT_TICK) begin
                r_owner <= NO_OWNER;
            end
            if (i_cmd.exec) begin
                unique case (r_act)
                    ACT_READ: begin
                        if (r_off == OFF_DMAOR && r_ch == 2'd0)
                            r_flags_rd <= r_flags_rd | r_dmaor[2:1];
                        if (r_off == OFF_CHCR && r_chcr[r_ch][1]) r_te_seen[r_ch] <= 1'b1;
                    end
                    ACT_WRITE: begin
                        unique case (r_off)
                            OFF_SAR_HI: r_sar[r_ch][31:16] <= r_wd;
                            OFF_SAR_LO: r_sar[r_ch][15:0]  <= r_wd;
                            OFF_DAR_HI: r_dar[r_ch][31:16] <= r_wd;
                            OFF_DAR_LO: r_dar[r_ch][15:0]  <= r_wd;
                            OFF_DMAOR: begin
                                if (r_ch == 2'd0) begin
                                    r_flags_rd <= '0;
                                    r_dmaor <= (r_wd & DMAOR_WR_MASK) |
                                        {13'd0, r_dmaor[2:1] & ~(r_flags_rd & ~r_wd[2:1]), 1'b0};
                                end
                            end
                            OFF_TCR: r_tcr[r_ch] <= r_wd;
                            OFF_CHCR: begin
                                r_te_seen[r_ch] <= 1'b0;
                                r_chcr[r_ch] <= {r_wd[15:2], r_chcr[r_ch][1] &&
                                    !(!r_wd[1] && r_te_seen[r_ch]), r_wd[0]};
                            end
                            default: ;
                        endcase
                    end
                    ACT_DREQ: begin
                        if (!r_ch[1]) begin
                            if (r_low && !r_level[r_ch[0]]) r_edge[r_ch[0]] <= 1'b1;
                            r_level[r_ch[0]] <= r_low;
                        end
                    end
                    ACT_NMI: r_dmaor[1] <= 1'b1;
                    default: ;
                endcase
            end
            if (i_cmd.push) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act <= i_action;
            r_ch  <= i_item[1:0];
            r_off <= i_item[4:2];
            r_wd  <= i_item[20:5];
            r_low <= i_item[21];
            r_req <= i_item[25:22];
        end
        if (do_unit) begin
            r_res.read_data <= '0;
            r_res.xvalid    <= 1'b1;
            r_res.ch        <= u;
            r_res.src       <= OutAddrBits'(r_sar[u] & amw);
            r_res.dst       <= OutAddrBits'(r_dar[u] & amw);
            r_res.word      <= word;
            r_res.src_dack  <= sd;
            r_res.dst_dack  <= dd;
            r_res.aerr      <= err;
        end else if (i_cmd.exec) begin
            r_res <= '{read_data: rd_val, default: '0};
        end
        if (i_cmd.push) begin
            r_out     <= i_cmd.push_blank ? '0 : r_res;
            r_oirq    <= irq_now;
            r_oserved <= i_cmd.push_served;
            r_olast   <= i_cmd.push_last;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_xfer   = r_out;
    assign o_irq    = r_oirq;
    assign o_served = r_oserved;
    assign o_last   = r_olast;

endmodule

// ----- rtl/core/four_channel_dma_controller_unit.sv -----
// Top level of the four-channel DMA controller: stream ports, controller
// state machine and datapath. Depends on fcdma_pkg, fcdma_ctrl and fcdma_dp.
//
// Usage: each transfer on the slave stream is one item: a register read or
// write, a DREQ pin change, a service tick, an on-chip module request or an
// NMI, with the action code in s_tuser. Each item yields one result transfer
// on the master stream, or up to four for a module request that several
// channels serve; the final result of an item carries tlast.
// Sequencing: an item is taken when the block is idle, executed in the next
// cycle, and its result is loaded into the output register once that
// register is free. The block does not take a new item before it is
// through with the last one. A module request scans the four channels
// one per cycle while no result waits for a free output register; each
// served channel adds a step that hands on its result. The next item is
// accepted as soon as the last result has moved into the output register,
// even while that result still waits.
// When the receiver stalls, the output register holds its result and the
// controller waits before loading the next one; no result is lost.
// Reset, synchronous and active low, clears all channel registers, DMAOR,
// the DREQ tracking and the burst owner, and empties the output register.
module four_channel_dma_controller_unit import fcdma_pkg::*; #(
    parameter int ADDR_BITS = DefaultAddrBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // channel[1:0], reg_offset[4:2], write_data[20:5], dreq_level_low[21],
    // request_source[25:22], zero fill above
    input  logic [31:0] i_s_tdata,
    // action[2:0]
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // read_data[15:0], irq_lines[19:16], xfer_channel[21:20],
    // xfer_src_addr[49:22], xfer_dst_addr[77:50], xfer_word[78],
    // source_dack[79], dest_dack[80], addr_error[81], source_served[82],
    // zero fill above
    output logic [87:0] o_m_tdata,
    // xfer_valid[0]
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    t_dp_cmd    cmd;
    t_dp_status status;
    t_xfer      xfer;
    logic [3:0] irq;
    logic       served;

    // The controller only sequences; all channel state lives in the datapath.
    fcdma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fcdma_dp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_action (i_s_tuser),
        .i_item   (i_s_tdata[25:0]),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_xfer   (xfer),
        .o_irq    (irq),
        .o_served (served),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {5'd0, served, xfer.aerr, xfer.dst_dack, xfer.src_dack, xfer.word,
                        xfer.dst, xfer.src, xfer.ch, irq, xfer.read_data};
    assign o_m_tuser = xfer.xvalid;

endmodule
